### hdl/lprd_pkg.sv
// Shared types, constants and codes of the length-prefixed record deframer.
package lprd_pkg;

    // Record header layout
    localparam int HEADER_BYTES  = 8;
    localparam int LENGTH_OFFSET = 0;
    localparam int TYPE_OFFSET   = 4;
    localparam int LENGTH_BYTES  = 4;

    // Widths of the record state and registers
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 32;
    localparam int TYPE_W = 8;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]  MAX_RECORD_RESET = 32'd65536;
    localparam logic [TYPE_W-1:0] MAX_TYPE_RESET   = 8'd255;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TYPE         = 2'd1;

    // Result queue between classifier and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Error codes reported with a word
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_TYPE     = 2'd2,
        ERR_OVERLONG = 2'd3
    } t_err;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
    } t_in_item;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       record_first;
        logic       record_last;
        logic [1:0] error_code;
    } t_out_item;

endpackage

### hdl/lprd_front.sv
// Classifier: tracks record position and header fields, tags each word.
module lprd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  lprd_pkg::t_in_item              i_item,
    input  logic                            i_cfg_valid,
    input  logic [lprd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output lprd_pkg::t_out_item             o_result
);

    localparam logic [lprd_pkg::CNT_W-1:0] LEN_LO =
        lprd_pkg::CNT_W'(lprd_pkg::LENGTH_OFFSET);
    localparam logic [lprd_pkg::CNT_W-1:0] LEN_HI =
        lprd_pkg::CNT_W'(lprd_pkg::LENGTH_OFFSET + lprd_pkg::LENGTH_BYTES);
    localparam logic [lprd_pkg::CNT_W-1:0] HDR_BYTES =
        lprd_pkg::CNT_W'(lprd_pkg::HEADER_BYTES);
    localparam logic [lprd_pkg::CNT_W-1:0] HDR_LAST =
        lprd_pkg::CNT_W'(lprd_pkg::HEADER_BYTES - 1);
    localparam logic [lprd_pkg::CNT_W-1:0] TYPE_POS =
        lprd_pkg::CNT_W'(lprd_pkg::TYPE_OFFSET);
    localparam logic TYPE_IN_HDR = (lprd_pkg::TYPE_OFFSET < lprd_pkg::HEADER_BYTES);

    logic [lprd_pkg::LEN_W-1:0]  r_max_record;
    logic [lprd_pkg::TYPE_W-1:0] r_max_type;
    logic [lprd_pkg::CNT_W-1:0]  r_count, n_count;
    logic [lprd_pkg::LEN_W-1:0]  r_len, n_len;
    logic                        r_discard, n_discard;

    logic [lprd_pkg::LEN_W-1:0]  len_new;
    logic                        gather;
    logic                        err_len;
    logic                        err_over;
    logic                        err_type;
    logic                        rec_end;
    lprd_pkg::t_err              err;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_record <= lprd_pkg::MAX_RECORD_RESET;
            r_max_type   <= lprd_pkg::MAX_TYPE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lprd_pkg::CFG_MAX_RECORD_BYTES: r_max_record <= i_cfg_data;
                lprd_pkg::CFG_MAX_TYPE: r_max_type <= i_cfg_data[lprd_pkg::TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // Gather the big-endian length and evaluate the checks
    always_comb begin
        gather  = (r_count >= LEN_LO) && (r_count < LEN_HI) && (r_count < HDR_BYTES);
        len_new = gather ? {r_len[lprd_pkg::LEN_W-9:0], i_item.data_byte} : r_len;
        err_len  = (r_count == HDR_LAST) && (len_new > r_max_record);
        err_over = (r_count >= r_max_record);
        err_type = TYPE_IN_HDR && (r_count == TYPE_POS) &&
                   (i_item.data_byte > r_max_type);
        rec_end  = (r_count >= HDR_LAST) &&
                   ({1'b0, r_count} == ({1'b0, HDR_LAST} + {1'b0, len_new}));
        if (err_len) begin
            err = lprd_pkg::ERR_LENGTH;
        end else if (err_over) begin
            err = lprd_pkg::ERR_OVERLONG;
        end else if (err_type) begin
            err = lprd_pkg::ERR_TYPE;
        end else begin
            err = lprd_pkg::ERR_NONE;
        end
    end

    // Build the result word and the next record state
    always_comb begin
        o_result.out_byte     = i_item.data_byte;
        o_result.byte_valid   = 1'b0;
        o_result.record_first = 1'b0;
        o_result.record_last  = 1'b0;
        o_result.error_code   = lprd_pkg::ERR_NONE;
        n_count   = r_count;
        n_len     = r_len;
        n_discard = r_discard;
        if (r_discard) begin
            if (i_item.packet_last) begin
                n_discard = 1'b0;
            end
        end else if (err != lprd_pkg::ERR_NONE) begin
            o_result.error_code = err;
            n_count   = '0;
            n_len     = '0;
            n_discard = !i_item.packet_last;
        end else begin
            o_result.byte_valid   = 1'b1;
            o_result.record_first = (r_count == '0);
            o_result.record_last  = rec_end;
            if (rec_end) begin
                n_count = '0;
                n_len   = '0;
            end else begin
                n_count = r_count + 1'b1;
                n_len   = len_new;
            end
        end
    end

    // Advance record state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_len     <= '0;
            r_discard <= 1'b0;
        end else if (i_accept) begin
            r_count   <= n_count;
            r_len     <= n_len;
            r_discard <= n_discard;
        end
    end

endmodule

### hdl/lprd_queue.sv
// Short result queue between the classifier and the output stage.
module lprd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  lprd_pkg::t_out_item i_wdata,
    input  logic                i_rd,
    output lprd_pkg::t_out_item o_rdata,
    output logic                o_full,
    output logic                o_empty
);

    lprd_pkg::t_out_item                r_mem [lprd_pkg::QUEUE_DEPTH];
    logic [lprd_pkg::QUEUE_AW-1:0]      r_wr_ptr;
    logic [lprd_pkg::QUEUE_AW-1:0]      r_rd_ptr;
    logic [lprd_pkg::QUEUE_AW:0]        r_count;

    assign o_full  = (r_count == (lprd_pkg::QUEUE_AW+1)'(lprd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Store incoming words
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == lprd_pkg::QUEUE_AW'(lprd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == lprd_pkg::QUEUE_AW'(lprd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/lprd_back.sv
// Output stage: holds the oldest result word until it is popped.
module lprd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  lprd_pkg::t_out_item i_q_data,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output lprd_pkg::t_out_item o_result
);

    logic                r_valid;
    lprd_pkg::t_out_item r_data;

    // Refill when the register is free or is being taken
    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_result = r_data;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_data <= i_q_data;
        end
    end

endmodule

### hdl/length_prefixed_record_deframer_unit.sv
// Top level of the length-prefixed record deframer.
// Throughput: one word per cycle while full is low; each accepted word gives exactly one result word.
// An accepted word is written into the queue, then loaded into the output register, where it shows with empty low.
// The classifier decides each word in its accept cycle; a 4-entry queue and an output
// register follow, so full rises only when four results wait behind an unpopped one.
// Reset (synchronous, i_rst_n low): queue and output empty, record state cleared,
// max_record_bytes = 65536, max_type = 255.
module length_prefixed_record_deframer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  lprd_pkg::t_in_item              i_item,
    output logic                            empty,
    input  logic                            pop,
    output lprd_pkg::t_out_item             o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lprd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    logic                accept;
    logic                q_rd;
    logic                q_empty;
    lprd_pkg::t_out_item front_result;
    lprd_pkg::t_out_item q_data;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    // Classify words
    lprd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (front_result)
    );

    // Decouple classifier from consumer
    lprd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_result),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // Present results
    lprd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

### hdl/lprd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
module lprd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic                            empty,
    input  logic                            pop,
    input  lprd_pkg::t_out_item             o_result
);

    // An error word is never passed on as record data
    a_err_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error_code != lprd_pkg::ERR_NONE) |->
        (!o_result.byte_valid && !o_result.record_first && !o_result.record_last))
        else $error("error word marked as record data");

    // Record marks only on valid words
    a_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.record_first || o_result.record_last)) |->
        o_result.byte_valid)
        else $error("record mark on discarded word");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // Reset leaves both sides idle
    a_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("not idle after reset");

    // A result shows only after an accepted push or a waiting word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(empty) && !empty) |-> ($past(push && !full, 2) || $past(full)
            || $past(push && !full, 3) || $past(!empty, 2)))
        else $error("result appeared without input");

endmodule

bind length_prefixed_record_deframer_unit lprd_checker u_lprd_checker (.*);

### bench/length_prefixed_record_deframer_unit_test.sv
// Testbench of the length-prefixed record deframer: scoreboard, stimulus and word checks.
`timescale 1ns / 1ps

module length_prefixed_record_deframer_unit_test;
    import lprd_pkg::*;

    // Indexes that map to no register; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int MAX_PRINTED = 40;

    // Tracks record framing per accepted word and checks the words that come out
    class deframe_checker;
        logic [LEN_W-1:0]  max_len;
        logic [TYPE_W-1:0] max_kind;
        logic [CNT_W-1:0]  rec_pos;
        logic [LEN_W-1:0]  rec_len;
        bit                dropping;
        t_out_item         pending_words[$];
        int                mismatches;
        int                words_in;
        int                records_done;
        int                err_hits[4];

        function new();
            max_len      = MAX_RECORD_RESET;
            max_kind     = MAX_TYPE_RESET;
            rec_pos      = '0;
            rec_len      = '0;
            dropping     = 1'b0;
            mismatches   = 0;
            words_in     = 0;
            records_done = 0;
            foreach (err_hits[i]) err_hits[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_MAX_RECORD_BYTES: max_len = val;
                CFG_MAX_TYPE:         max_kind = val[TYPE_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the result word for one accepted input word
        function void note_word(t_in_item w);
            t_out_item        e;
            logic [CNT_W:0]   pos;
            logic [LEN_W-1:0] len;
            t_err             code;
            bit               ends;
            e = '0;
            e.out_byte = w.data_byte;
            words_in++;
            // drop up to the end of the packet
            if (dropping) begin
                if (w.packet_last) dropping = 1'b0;
                pending_words.push_back(e);
                return;
            end
            pos  = {1'b0, rec_pos};
            len  = rec_len;
            code = ERR_NONE;
            if (pos >= LENGTH_OFFSET && pos < LENGTH_OFFSET + LENGTH_BYTES && pos < HEADER_BYTES)
                len = {len[LEN_W-9:0], w.data_byte};
            // length beats overlong, overlong beats type
            if (pos == HEADER_BYTES - 1 && len > max_len)
                code = ERR_LENGTH;
            else if (pos + 1 > max_len)
                code = ERR_OVERLONG;
            else if (pos == TYPE_OFFSET && pos < HEADER_BYTES && w.data_byte > max_kind)
                code = ERR_TYPE;
            if (code != ERR_NONE) begin
                e.error_code = code;
                err_hits[code]++;
                rec_pos  = '0;
                rec_len  = '0;
                dropping = !w.packet_last;
            end else begin
                ends = (pos >= HEADER_BYTES - 1) && (pos == {1'b0, len} + (HEADER_BYTES - 1));
                e.byte_valid   = 1'b1;
                e.record_first = (pos == 0);
                e.record_last  = ends;
                if (ends) begin
                    rec_pos = '0;
                    rec_len = '0;
                    records_done++;
                end else begin
                    rec_pos = pos[CNT_W-1:0] + 1'b1;
                    rec_len = len;
                end
            end
            pending_words.push_back(e);
        endfunction

        task flag_mismatch(string what, t_out_item got, t_out_item want);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t mismatch on %s: got %h/%b/%b/%b/%0d, want %h/%b/%b/%b/%0d",
                         $realtime, what, got.out_byte, got.byte_valid, got.record_first,
                         got.record_last, got.error_code, want.out_byte, want.byte_valid,
                         want.record_first, want.record_last, want.error_code);
        endtask

        // Compare one popped word with the oldest expectation
        task check_word(t_out_item got);
            t_out_item want;
            if (pending_words.size() == 0) begin
                flag_mismatch("word with nothing expected", got, got);
                return;
            end
            want = pending_words.pop_front();
            if (got.out_byte !== want.out_byte)         flag_mismatch("out_byte", got, want);
            if (got.byte_valid !== want.byte_valid)     flag_mismatch("byte_valid", got, want);
            if (got.record_first !== want.record_first) flag_mismatch("record_first", got, want);
            if (got.record_last !== want.record_last)   flag_mismatch("record_last", got, want);
            if (got.error_code !== want.error_code)     flag_mismatch("error_code", got, want);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_in_item             i_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_out_item            o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    int send_idle = 31;
    int take_idle = 73;
    int settings_run = 0;
    deframe_checker tracker;

    length_prefixed_record_deframer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pop side: check each popped word, then pick the next pop level
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) tracker.check_word(o_result);
            pop <= ($urandom_range(0, 99) >= take_idle);
        end
    end

    // Push one word, idling first at random, and hold it until accepted
    task push_word(input logic [7:0] b, input bit last);
        if ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_item <= '{data_byte: b, packet_last: last};
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        tracker.note_word('{data_byte: b, packet_last: last});
    endtask

    // Push a header with the given length and type, then payload_n words
    task send_record(input logic [31:0] len, input logic [7:0] kind, input int payload_n,
                     input int fill, input int break_pct, input bit end_pkt);
        int         total;
        logic [7:0] b;
        bit         last;
        total = HEADER_BYTES + payload_n;
        for (int i = 0; i < total; i++) begin
            if (i >= LENGTH_OFFSET && i < LENGTH_OFFSET + LENGTH_BYTES)
                b = 8'(len >> (8 * (LENGTH_OFFSET + LENGTH_BYTES - 1 - i)));
            else if (i == TYPE_OFFSET)
                b = kind;
            else
                b = (fill < 0) ? 8'($urandom) : 8'(fill);
            last = (i == total - 1) ? end_pkt : ($urandom_range(0, 99) < break_pct);
            push_word(b, last);
        end
    endtask

    // Bring the stream back to a record boundary after noise or an error
    task realign();
        while (!tracker.dropping && tracker.rec_pos != 0 && tracker.rec_pos < HEADER_BYTES)
            push_word(8'h00, 1'b0);
        while (!tracker.dropping && tracker.rec_pos != 0 && tracker.rec_len <= 100)
            push_word(8'($urandom), 1'b0);
        if (tracker.dropping) push_word(8'($urandom), 1'b1);
    endtask

    // Mostly well-formed records with random content, some limit hits and noise
    task run_random(input int n, input int noise_pct);
        int          target;
        int          sel;
        int          pay;
        logic [31:0] len;
        logic [7:0]  kind;
        bit          end_pkt;
        target = tracker.words_in + n;
        while (tracker.words_in < target) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                repeat ($urandom_range(1, 10)) push_word(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                realign();
                sel     = $urandom_range(0, 9);
                end_pkt = $urandom_range(0, 1);
                if (sel == 0 && tracker.max_len != '1) begin
                    len     = tracker.max_len + 1;
                    end_pkt = 1'b1;
                end else if (sel == 1 && tracker.max_len != '1) begin
                    len = $urandom;
                    if (len <= tracker.max_len) len = tracker.max_len + 1;
                    end_pkt = 1'b1;
                end else if (sel == 2 && tracker.max_len <= 72) begin
                    len = (tracker.max_len < HEADER_BYTES) ? $urandom_range(0, 3) :
                          tracker.max_len - HEADER_BYTES + $urandom_range(0, 1);
                end else begin
                    len = $urandom_range(0, 20);
                end
                kind = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                       8'($urandom_range(0, tracker.max_kind));
                pay  = (len <= 64) ? int'(len) : $urandom_range(0, 6);
                send_record(len, kind, pay, -1, 6, end_pkt);
            end
        end
    endtask

    // Hold off pushing until every expected word has been popped
    task wait_for_results();
        push <= 1'b0;
        while (tracker.pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limits: header-only record, maximal type, length over the limit
        settings_run++;
        send_record(32'd0, 8'h00, 0, 0, 0, 1'b1);
        send_record(32'd1, 8'hFF, 1, 255, 0, 1'b0);
        send_record(32'h0001_0001, 8'h00, 2, 255, 0, 1'b1);
        run_random(180, 10);

        // Tight limits: type over the limit, record one word overlong
        wait_for_results();
        settings_run++;
        write_reg(CFG_MAX_RECORD_BYTES, 32'd20);
        write_reg(CFG_MAX_TYPE, 32'hFFFF_FF64);
        send_record(32'd4, 8'd101, 4, -1, 0, 1'b1);
        send_record(32'd13, 8'd100, 13, -1, 0, 1'b1);
        run_random(90, 10);
        wait_for_results();
        run_random(90, 10);

        // Zero record limit: every word not dropped is overlong
        wait_for_results();
        settings_run++;
        send_idle = 73;
        take_idle = 31;
        write_reg(CFG_MAX_RECORD_BYTES, 32'd0);
        write_reg(CFG_MAX_TYPE, 32'h0000_00FF);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        run_random(150, 10);

        // Widest record limit, zero type limit; no noise so records stay aligned
        wait_for_results();
        settings_run++;
        write_reg(CFG_MAX_RECORD_BYTES, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_TYPE, 32'd0);
        run_random(180, 0);

        // Small limits at full rate
        wait_for_results();
        settings_run++;
        send_idle = 0;
        take_idle = 0;
        write_reg(CFG_MAX_RECORD_BYTES, 32'd9);
        write_reg(CFG_MAX_TYPE, 32'd3);
        run_random(180, 10);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d words under %0d limit settings: %0d whole records, %0d error words",
                 tracker.words_in, settings_run, tracker.records_done,
                 tracker.err_hits[ERR_LENGTH] + tracker.err_hits[ERR_TYPE] +
                 tracker.err_hits[ERR_OVERLONG]);
        $display("Errors by kind: length %0d, type %0d, overlong %0d; %0d word mismatches",
                 tracker.err_hits[ERR_LENGTH], tracker.err_hits[ERR_TYPE],
                 tracker.err_hits[ERR_OVERLONG], tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hdl/lprd_pkg.sv
hdl/lprd_front.sv
hdl/lprd_queue.sv
hdl/lprd_back.sv
hdl/length_prefixed_record_deframer_unit.sv
hdl/lprd_checker.sv
bench/length_prefixed_record_deframer_unit_test.sv
